### src/cpctm_pkg.sv
// ----------------------------------------------------------------------------
// cpctm_pkg
// shared constants and codes of the cyclic prefix correlation timing metric
// ----------------------------------------------------------------------------
package cpctm_pkg;

    localparam int SMP_W      = 16;
    localparam int MET_W      = 16;
    localparam int WIN_W      = 24;
    localparam int FFT_REG_W  = 12;
    localparam int CP_REG_W   = 10;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FFT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CP_LEN  = 2'd1;

    localparam logic [FFT_REG_W-1:0] FFT_LEN_RST = 12'd64;
    localparam logic [CP_REG_W-1:0]  CP_LEN_RST  = 10'd16;

    localparam int DEF_MAX_FFT     = 2048;
    localparam int DEF_MAX_CP      = 512;
    localparam int DEF_SAMPLE_BITS = 16;

endpackage

### src/cpctm_ifs.sv
// ----------------------------------------------------------------------------
// cpctm channel interfaces
// sample channel and metric channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface cpctm_in_if
    import cpctm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample_i;
    logic [SMP_W-1:0] sample_q;
    logic             restart;

    modport source (output valid, output sample_i, output sample_q, output restart,
                    input ready);
    modport sink   (input valid, input sample_i, input sample_q, input restart,
                    output ready);
endinterface

interface cpctm_out_if
    import cpctm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [MET_W-1:0] metric;
    logic [WIN_W-1:0] window_start;

    modport source (output valid, output metric, output window_start, input ready);
    modport sink   (input valid, input metric, input window_start, output ready);
endinterface

### src/cpctm_front.sv
// ----------------------------------------------------------------------------
// cpctm_front
// accepts samples, keeps the delay line and the running window sums
// ----------------------------------------------------------------------------
module cpctm_front
    import cpctm_pkg::*;
#(
    parameter int MAX_FFT     = DEF_MAX_FFT,
    parameter int MAX_CP      = DEF_MAX_CP,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int ACC_W       = 2 * DEF_SAMPLE_BITS + 11,
    parameter int EN_W        = 2 * DEF_SAMPLE_BITS + 10,
    parameter int SNAP_W      = 2 * ACC_W + 2 * EN_W + WIN_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cpctm_in_if.sink              i_smp,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [SNAP_W-1:0]     o_push_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int HD   = MAX_FFT + MAX_CP;
    localparam int HA_W = $clog2(HD);
    localparam int D_W  = $clog2(HD + 1);
    localparam int F_W  = $clog2(MAX_FFT + 1);
    localparam int C_W  = $clog2(MAX_CP + 1);
    localparam int P_W  = 2 * SB;

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_RD_E  = 7'b0000010,
        F_RD_LE = 7'b0000100,
        F_RD_LB = 7'b0001000,
        F_MUL_L = 7'b0010000,
        F_ACC_L = 7'b0100000,
        F_PUSH  = 7'b1000000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [FFT_REG_W-1:0] r_fft;
    logic [CP_REG_W-1:0]  r_cp;
    logic [HA_W-1:0]      r_wr;
    logic [D_W-1:0]       r_fill;
    logic signed [ACC_W-1:0] r_cr, r_ci;
    logic [EN_W-1:0]      r_ea, r_eb;
    logic [WIN_W-1:0]     r_wi;

    logic [2*SB-1:0] r_hist [HD];
    logic [2*SB-1:0] r_rd, r_x, r_le;
    logic            hist_we;
    logic [HA_W-1:0] rd_addr;

    logic signed [P_W-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_na, r_nb;

    logic signed [SB-1:0] xr, xq;
    logic [F_W-1:0] f_eff;
    logic [C_W-1:0] c_eff;
    logic [D_W-1:0] f_d, c_d, fc_d, fill_inc;
    logic           have_e, have_l, emit;

    logic signed [SB-1:0] ar, ai, br, bi;
    logic signed [P_W:0]  d_re, d_im;

    // sample truncated to the active width, or sign extended when that is wider
    if (SB <= SMP_W) begin : g_narrow
        assign xr = i_smp.sample_i[SB-1:0];
        assign xq = i_smp.sample_q[SB-1:0];
    end else begin : g_wide
        assign xr = SB'(signed'(i_smp.sample_i));
        assign xq = SB'(signed'(i_smp.sample_q));
    end

    always_comb begin
        if (r_fft == '0) f_eff = F_W'(1);
        else if (32'(r_fft) > 32'(MAX_FFT)) f_eff = F_W'(MAX_FFT);
        else f_eff = F_W'(r_fft);
        if (r_cp == '0) c_eff = C_W'(1);
        else if (32'(r_cp) > 32'(MAX_CP)) c_eff = C_W'(MAX_CP);
        else c_eff = C_W'(r_cp);
    end

    assign f_d      = D_W'(f_eff);
    assign c_d      = D_W'(c_eff);
    assign fc_d     = f_d + c_d;
    assign fill_inc = r_fill + D_W'(1);
    assign have_e   = r_fill >= f_d;
    assign have_l   = r_fill >= fc_d;
    assign emit     = fill_inc >= fc_d;

    function automatic logic [HA_W-1:0] back_addr(input logic [HA_W-1:0] wr,
                                                  input logic [D_W-1:0] d);
        logic [D_W:0] t;
        t = (D_W+1)'(wr) - (D_W+1)'(d);
        if (t[D_W]) t = t + (D_W+1)'(HD);
        return HA_W'(t);
    endfunction

    always_comb begin
        unique case (r_state)
            F_RD_LE: rd_addr = back_addr(r_wr, fc_d);
            F_RD_LB: rd_addr = back_addr(r_wr, c_d);
            default: rd_addr = back_addr(r_wr, f_d);
        endcase
    end

    assign hist_we = (r_state == F_ACC_L);

    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist[r_wr] <= r_x;
        r_rd <= r_hist[rd_addr];
    end

    // product lanes: entering pair first, leaving pair second
    always_comb begin
        if (r_state == F_RD_LE) begin
            ar = r_rd[SB-1:0];  ai = r_rd[2*SB-1:SB];
            br = r_x[SB-1:0];   bi = r_x[2*SB-1:SB];
        end else begin
            ar = r_le[SB-1:0];  ai = r_le[2*SB-1:SB];
            br = r_rd[SB-1:0];  bi = r_rd[2*SB-1:SB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_RD_LE || r_state == F_MUL_L) begin
            r_p_rr <= ar * br;
            r_p_ii <= ai * bi;
            r_p_ir <= ai * br;
            r_p_ri <= ar * bi;
            r_na   <= ar * ar + ai * ai;
            r_nb   <= br * br + bi * bi;
        end
        if (r_state == F_RD_LB) r_le <= r_rd;
        if (r_state == F_IDLE && i_smp.valid) r_x <= {xq, xr};
    end

    assign d_re = (P_W+1)'(r_p_rr) + (P_W+1)'(r_p_ii);
    assign d_im = (P_W+1)'(r_p_ir) - (P_W+1)'(r_p_ri);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_smp.valid) n_state = F_RD_E;
            F_RD_E:  n_state = F_RD_LE;
            F_RD_LE: n_state = F_RD_LB;
            F_RD_LB: n_state = F_MUL_L;
            F_MUL_L: n_state = F_ACC_L;
            F_ACC_L: n_state = emit ? F_PUSH : F_IDLE;
            F_PUSH:  if (i_push_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_fft   <= FFT_LEN_RST;
            r_cp    <= CP_LEN_RST;
            r_wr    <= '0;
            r_fill  <= '0;
            r_cr    <= '0;
            r_ci    <= '0;
            r_ea    <= '0;
            r_eb    <= '0;
            r_wi    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx == CFG_FFT_LEN || i_cfg_idx == CFG_CP_LEN)) begin
                if (i_cfg_idx == CFG_FFT_LEN) r_fft <= i_cfg_data[FFT_REG_W-1:0];
                else r_cp <= i_cfg_data[CP_REG_W-1:0];
                r_wr   <= '0;
                r_fill <= '0;
                r_cr   <= '0;
                r_ci   <= '0;
                r_ea   <= '0;
                r_eb   <= '0;
                r_wi   <= '0;
            end else begin
                unique case (r_state)
                    F_IDLE: begin
                        if (i_smp.valid && i_smp.restart) begin
                            r_wr   <= '0;
                            r_fill <= '0;
                            r_cr   <= '0;
                            r_ci   <= '0;
                            r_ea   <= '0;
                            r_eb   <= '0;
                            r_wi   <= '0;
                        end
                    end
                    F_RD_LB: begin
                        if (have_e) begin
                            r_cr <= r_cr + ACC_W'(d_re);
                            r_ci <= r_ci + ACC_W'(d_im);
                            r_ea <= r_ea + EN_W'(unsigned'(r_na));
                            r_eb <= r_eb + EN_W'(unsigned'(r_nb));
                        end
                    end
                    F_ACC_L: begin
                        if (have_l) begin
                            r_cr <= r_cr - ACC_W'(d_re);
                            r_ci <= r_ci - ACC_W'(d_im);
                            r_ea <= r_ea - EN_W'(unsigned'(r_na));
                            r_eb <= r_eb - EN_W'(unsigned'(r_nb));
                        end
                        r_wr   <= (r_wr == HA_W'(HD - 1)) ? '0 : r_wr + HA_W'(1);
                        r_fill <= (fill_inc > fc_d) ? fc_d : fill_inc;
                    end
                    F_PUSH: if (i_push_ready) r_wi <= r_wi + WIN_W'(1);
                    default: ;
                endcase
            end
        end
    end

    assign i_smp.ready  = (r_state == F_IDLE);
    assign o_push_valid = (r_state == F_PUSH);
    assign o_push_data  = {r_wi, r_eb, r_ea, r_ci, r_cr};

endmodule

### src/cpctm_queue.sv
// ----------------------------------------------------------------------------
// cpctm_queue
// two-entry queue of window snapshots between front and back
// ----------------------------------------------------------------------------
module cpctm_queue
    import cpctm_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

### src/cpctm_back.sv
// ----------------------------------------------------------------------------
// cpctm_back
// normalizes a window snapshot into the metric with shift-add units
// ----------------------------------------------------------------------------
module cpctm_back
    import cpctm_pkg::*;
#(
    parameter int ACC_W  = 2 * DEF_SAMPLE_BITS + 11,
    parameter int EN_W   = 2 * DEF_SAMPLE_BITS + 10,
    parameter int SNAP_W = 2 * ACC_W + 2 * EN_W + WIN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  logic [SNAP_W-1:0] i_pop_data,
    cpctm_out_if.source       o_res
);

    localparam int MW   = 2 * ACC_W;
    localparam int PW   = MW + 2 * MET_W + 2;
    localparam int MC_W = $clog2(ACC_W + 1);

    typedef enum logic [8:0] {
        B_IDLE = 9'b000000001,
        B_AB   = 9'b000000010,
        B_CR   = 9'b000000100,
        B_CI   = 9'b000001000,
        B_SUM  = 9'b000010000,
        B_RHS  = 9'b000100000,
        B_SQA  = 9'b001000000,
        B_SQB  = 9'b010000000,
        B_OUT  = 9'b100000000
    } t_bstate;

    t_bstate r_state;

    logic signed [ACC_W-1:0] s_cr, s_ci;
    logic [EN_W-1:0]  s_a, s_b;
    logic [WIN_W-1:0] s_wi;

    logic [ACC_W-1:0] r_ci_mag;
    logic [MW-1:0]    r_mc, r_acc, r_ab, r_sq;
    logic [ACC_W-1:0] r_mp;
    logic [MC_W-1:0]  r_cnt;
    logic [MW:0]      r_s;
    logic [PW-1:0]    r_rhs, r_p, r_u, r_t, r_cand;
    logic [MET_W-1:0] r_m, r_bit, r_met;
    logic [WIN_W-1:0] r_wi;

    logic [MW-1:0] acc_next;
    logic          mul_last;

    assign {s_wi, s_b, s_a, s_ci, s_cr} = i_pop_data;

    assign acc_next = r_acc + (r_mp[0] ? r_mc : '0);
    assign mul_last = (r_cnt == MC_W'(ACC_W - 1));

    function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    assign o_pop_ready = (r_state == B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_pop_valid) begin
                        r_wi     <= s_wi;
                        r_ci_mag <= mag(s_ci);
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        if (s_a == '0 || s_b == '0) begin
                            r_met   <= '0;
                            r_state <= B_OUT;
                        end else begin
                            r_mc    <= MW'(s_a);
                            r_mp    <= ACC_W'(s_b);
                            r_state <= B_AB;
                        end
                        r_sq <= MW'(mag(s_cr));
                    end
                end
                B_AB, B_CR, B_CI: begin
                    r_acc <= acc_next;
                    r_mc  <= r_mc << 1;
                    r_mp  <= r_mp >> 1;
                    r_cnt <= r_cnt + MC_W'(1);
                    if (mul_last) begin
                        r_acc <= '0;
                        r_cnt <= '0;
                        if (r_state == B_AB) begin
                            r_ab    <= acc_next;
                            r_mc    <= r_sq;
                            r_mp    <= ACC_W'(r_sq);
                            r_state <= B_CR;
                        end else if (r_state == B_CR) begin
                            r_sq    <= acc_next;
                            r_mc    <= MW'(r_ci_mag);
                            r_mp    <= r_ci_mag;
                            r_state <= B_CI;
                        end else begin
                            r_s     <= (MW+1)'(r_sq) + (MW+1)'(acc_next);
                            r_state <= B_SUM;
                        end
                    end
                end
                B_SUM: begin
                    // 65535^2 = 2^32 - 2^17 + 1
                    r_rhs   <= (PW'(r_s) << (2 * MET_W)) + PW'(r_s);
                    r_state <= B_RHS;
                end
                B_RHS: begin
                    r_rhs   <= r_rhs - (PW'(r_s) << (MET_W + 1));
                    r_p     <= '0;
                    r_u     <= '0;
                    r_t     <= PW'(r_ab) << (2 * (MET_W - 1));
                    r_m     <= '0;
                    r_bit   <= {1'b1, {(MET_W-1){1'b0}}};
                    r_state <= B_SQA;
                end
                B_SQA: begin
                    r_cand  <= r_p + r_u + r_t;
                    r_state <= B_SQB;
                end
                B_SQB: begin
                    if (r_cand <= r_rhs) begin
                        r_p <= r_cand;
                        r_u <= (r_u >> 1) + r_t;
                        r_m <= r_m | r_bit;
                    end else begin
                        r_u <= r_u >> 1;
                    end
                    r_t   <= r_t >> 2;
                    r_bit <= r_bit >> 1;
                    if (r_bit[0]) begin
                        r_met   <= (r_cand <= r_rhs) ? (r_m | r_bit) : r_m;
                        r_state <= B_OUT;
                    end else begin
                        r_state <= B_SQA;
                    end
                end
                B_OUT: if (o_res.ready) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_res.valid        = (r_state == B_OUT);
    assign o_res.metric       = r_met;
    assign o_res.window_start = r_wi;

endmodule

### src/cp_correlation_timing_metric.sv
// ----------------------------------------------------------------------------
// cp_correlation_timing_metric
// cyclic prefix correlation and normalized timing metric per sample
// ----------------------------------------------------------------------------
// channel  dir  payload                          transaction
// i_smp    in   sample_i, sample_q, restart      valid & ready
// o_res    out  metric, window_start             valid & ready
// i_cfg_*  in   register index, data             write enable
//
// the front walks a sample through its read, multiply and accumulate states and
// a push state when it emits a window snapshot (three delay line reads on one port),
// waits in the push state while the queue is full; the back runs three shift-add
// multiplications and a root step of two states per metric bit, which sets the sustained rate
// reset is synchronous; the delay line needs no clearing, the fill count guards it
// a two-entry queue lets the front run ahead while the output stalls
// ----------------------------------------------------------------------------
module cp_correlation_timing_metric
    import cpctm_pkg::*;
#(
    parameter int MAX_FFT     = DEF_MAX_FFT,
    parameter int MAX_CP      = DEF_MAX_CP,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cpctm_in_if.sink              i_smp,
    cpctm_out_if.source           o_res
);

    localparam int C_W    = $clog2(MAX_CP + 1);
    localparam int ACC_W  = 2 * SAMPLE_BITS + C_W + 1;
    localparam int EN_W   = 2 * SAMPLE_BITS + C_W;
    localparam int SNAP_W = 2 * ACC_W + 2 * EN_W + WIN_W;

    logic              push_valid, push_ready, pop_valid, pop_ready;
    logic [SNAP_W-1:0] push_data, pop_data;

    cpctm_front #(
        .MAX_FFT(MAX_FFT), .MAX_CP(MAX_CP), .SAMPLE_BITS(SAMPLE_BITS),
        .ACC_W(ACC_W), .EN_W(EN_W), .SNAP_W(SNAP_W)
    ) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_smp,
        .o_push_valid(push_valid), .i_push_ready(push_ready), .o_push_data(push_data)
    );

    cpctm_queue #(.DATA_W(SNAP_W)) u_queue (
        .i_clk, .i_rst_n,
        .i_push_valid(push_valid), .o_push_ready(push_ready), .i_push_data(push_data),
        .o_pop_valid(pop_valid), .i_pop_ready(pop_ready), .o_pop_data(pop_data)
    );

    cpctm_back #(.ACC_W(ACC_W), .EN_W(EN_W), .SNAP_W(SNAP_W)) u_back (
        .i_clk, .i_rst_n,
        .i_pop_valid(pop_valid), .o_pop_ready(pop_ready), .i_pop_data(pop_data),
        .o_res
    );

endmodule

### src/cpctm_checker.sv
// ----------------------------------------------------------------------------
// cpctm_assertions
// port-level checks of the timing metric block
// ----------------------------------------------------------------------------
module cpctm_assertions
    import cpctm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [MET_W-1:0] i_metric,
    input logic [WIN_W-1:0] i_window_start
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_metric)
            && $stable(i_window_start))
        else $error("stalled result changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("front took a second sample while busy");

    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("back results without a gap");

endmodule

bind cp_correlation_timing_metric cpctm_assertions u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_smp.valid),
    .i_in_ready(i_smp.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_metric(o_res.metric),
    .i_window_start(o_res.window_start)
);

### dv/cpctm_checker.sv
// ----------------------------------------------------------------------------
// cpctm_checker
// watches the sample, metric and register ports, keeps its own copy of the
// correlator state, predicts each metric and compares it with the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cpctm_checker
    import cpctm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cpctm_in_if                   smp,
    cpctm_out_if                  res,
    output int                    o_fail_cnt,
    output int                    o_pending
);

    localparam int HIST_N = DEF_MAX_FFT + DEF_MAX_CP;

    typedef struct packed {
        logic [MET_W-1:0] metric;
        logic [WIN_W-1:0] window_start;
    } metric_t;

    metric_t                 metric_q[$];
    logic signed [SMP_W-1:0] hist_i[HIST_N];
    logic signed [SMP_W-1:0] hist_q[HIST_N];
    int                      wr_pos;
    int                      fill_cnt;
    longint                  corr_re;
    longint                  corr_im;
    longint                  en_early;
    longint                  en_late;
    logic [WIN_W-1:0]        win_idx;
    logic [FFT_REG_W-1:0]    fft_reg;
    logic [CP_REG_W-1:0]     cp_reg;
    int                      fails;

    function automatic logic [MET_W-1:0] norm_metric(longint a, longint b,
                                                     longint cr, longint ci);
        logic [127:0]     ab;
        logic [127:0]     rhs;
        logic [127:0]     mr;
        logic [127:0]     mi;
        logic [127:0]     cand;
        logic [MET_W-1:0] m;
        if (a == 0 || b == 0) begin
            return '0;
        end
        ab  = 128'(a) * 128'(b);
        mr  = 128'(cr < 0 ? -cr : cr);
        mi  = 128'(ci < 0 ? -ci : ci);
        rhs = (mr * mr + mi * mi) * 128'(64'd4294836225);
        m   = '0;
        for (int bt = MET_W - 1; bt >= 0; bt--) begin
            cand = 128'(m | (16'd1 << bt));
            if (cand * cand * ab <= rhs) begin
                m = cand[MET_W-1:0];
            end
        end
        return m;
    endfunction

    function automatic int hist_pos(int d);
        return (wr_pos + HIST_N - d) % HIST_N;
    endfunction

    task automatic clear_stream();
        wr_pos   = 0;
        fill_cnt = 0;
        corr_re  = 0;
        corr_im  = 0;
        en_early = 0;
        en_late  = 0;
        win_idx  = '0;
    endtask

    task automatic predict_sample(logic signed [SMP_W-1:0] si,
                                  logic signed [SMP_W-1:0] sq, logic rs);
        int      f;
        int      c;
        int      n;
        int      p;
        longint  xr;
        longint  xq;
        longint  er;
        longint  eq;
        longint  br;
        longint  bq;
        metric_t exp_res;
        f = (fft_reg < 1) ? 1 : ((fft_reg > DEF_MAX_FFT) ? DEF_MAX_FFT : int'(fft_reg));
        c = (cp_reg < 1) ? 1 : ((cp_reg > DEF_MAX_CP) ? DEF_MAX_CP : int'(cp_reg));
        if (rs) begin
            clear_stream();
        end
        n  = fill_cnt;
        xr = longint'(si);
        xq = longint'(sq);
        if (n >= f) begin
            p = hist_pos(f);
            er = longint'(hist_i[p]);
            eq = longint'(hist_q[p]);
            corr_re  += er * xr + eq * xq;
            corr_im  += eq * xr - er * xq;
            en_early += er * er + eq * eq;
            en_late  += xr * xr + xq * xq;
        end
        if (n >= f + c) begin
            p  = hist_pos(f + c);
            er = longint'(hist_i[p]);
            eq = longint'(hist_q[p]);
            p  = hist_pos(c);
            br = longint'(hist_i[p]);
            bq = longint'(hist_q[p]);
            corr_re  -= er * br + eq * bq;
            corr_im  -= eq * br - er * bq;
            en_early -= er * er + eq * eq;
            en_late  -= br * br + bq * bq;
        end
        hist_i[wr_pos] = si;
        hist_q[wr_pos] = sq;
        wr_pos   = (wr_pos + 1) % HIST_N;
        fill_cnt = (n + 1 > f + c) ? f + c : n + 1;
        if (n + 1 >= f + c) begin
            exp_res.metric       = norm_metric(en_early, en_late, corr_re, corr_im);
            exp_res.window_start = win_idx;
            metric_q.insert(metric_q.size(), exp_res);
            win_idx = win_idx + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        metric_t exp_res;
        if (!i_rst_n) begin
            fft_reg = FFT_LEN_RST;
            cp_reg  = CP_LEN_RST;
            clear_stream();
            metric_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FFT_LEN) begin
                    fft_reg = i_cfg_data[FFT_REG_W-1:0];
                    clear_stream();
                end else if (i_cfg_idx == CFG_CP_LEN) begin
                    cp_reg = i_cfg_data[CP_REG_W-1:0];
                    clear_stream();
                end
            end
            if (smp.valid && smp.ready) begin
                predict_sample(smp.sample_i, smp.sample_q, smp.restart);
            end
            if (res.valid && res.ready) begin
                if (metric_q.size() == 0) begin
                    $error("unexpected metric transaction: metric %0d window_start %0d",
                           res.metric, res.window_start);
                    fails++;
                end else begin
                    exp_res = metric_q.pop_front();
                    if (res.metric !== exp_res.metric) begin
                        $error("metric: expected %0d actual %0d",
                               exp_res.metric, res.metric);
                        fails++;
                    end
                    if (res.window_start !== exp_res.window_start) begin
                        $error("window_start: expected %0d actual %0d",
                               exp_res.window_start, res.window_start);
                        fails++;
                    end
                end
            end
        end
        o_pending  <= metric_q.size();
        o_fail_cnt <= fails;
    end

endmodule

### dv/cp_correlation_timing_metric_tb.sv
// ----------------------------------------------------------------------------
// cp_correlation_timing_metric_tb
// drives samples and register settings into the correlator, stalls the
// metric output at random and once for a long stretch, and reports the
// verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cp_correlation_timing_metric_tb;
    import cpctm_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 300;
    localparam int HOLD_CYC   = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_cnt;
    int                    pending;
    logic                  noidle;
    logic                  hold_go;
    int                    wdog_cnt;

    logic [SMP_W-1:0]      sent_i[4096];
    logic [SMP_W-1:0]      sent_q[4096];
    int                    sent_cnt;
    int                    gen_fft;

    cpctm_in_if  smp_if();
    cpctm_out_if res_if();

    cp_correlation_timing_metric dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if),
        .o_res      (res_if)
    );

    cpctm_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .smp        (smp_if),
        .res        (res_if),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            wdog_cnt <= 0;
        end else begin
            wdog_cnt <= wdog_cnt + 1;
            if (wdog_cnt >= WDOG_LIMIT) begin
                $display("cp_correlation_timing_metric_tb failed");
                $finish;
            end
        end
    end

    // metric receiver
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= noidle || ($urandom_range(99) >= 11);
            end
        end
    end

    task automatic send_sample(logic [SMP_W-1:0] si, logic [SMP_W-1:0] sq, logic rs);
        if (!noidle && $urandom_range(99) < 11) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.sample_i <= si;
        smp_if.sample_q <= sq;
        smp_if.restart  <= rs;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        if (rs) begin
            sent_cnt = 0;
        end
        sent_i[sent_cnt % 4096] = si;
        sent_q[sent_cnt % 4096] = sq;
        sent_cnt++;
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_lengths(int fft, int cp);
        write_reg(CFG_FFT_LEN, CFG_DATA_W'(fft));
        write_reg(CFG_CP_LEN, CFG_DATA_W'(cp));
        i_cfg_we <= 1'b0;
        sent_cnt = 0;
        gen_fft  = (fft < 1) ? 1 : ((fft > DEF_MAX_FFT) ? DEF_MAX_FFT : fft);
    endtask

    // mostly prefix-like repeats of the sample one symbol back, some noise
    task automatic send_random(int n_items, int rs_pct = 2);
        int               r;
        int               p;
        logic [SMP_W-1:0] si;
        logic [SMP_W-1:0] sq;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 5) begin
                si = '0;
                sq = '0;
            end else if (sent_cnt >= gen_fft && r < 60) begin
                p  = (sent_cnt - gen_fft) % 4096;
                si = sent_i[p] ^ SMP_W'($urandom_range(0, 7));
                sq = sent_q[p] ^ SMP_W'($urandom_range(0, 7));
            end else begin
                si = SMP_W'($urandom);
                sq = SMP_W'($urandom);
            end
            send_sample(si, sq, ($urandom_range(99) < rs_pct));
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_FFT_LEN;
        i_cfg_data      <= '0;
        smp_if.valid    <= 1'b0;
        smp_if.sample_i <= '0;
        smp_if.sample_q <= '0;
        smp_if.restart  <= 1'b0;
        noidle          <= 1'b0;
        hold_go         <= 1'b0;
        sent_cnt = 0;
        gen_fft  = FFT_LEN_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lengths
        send_random(100);
        drain();

        // directed: extremes, zero energy, restart
        set_lengths(1, 1);
        send_sample(16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b0);
        send_sample(16'h7fff, 16'h7fff, 1'b0);
        send_sample(16'h7fff, 16'h7fff, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h7fff, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7fff, 1'b0);
        send_sample(16'h0000, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h0000, 1'b0);
        send_sample(16'hffff, 16'h0001, 1'b0);
        send_sample(16'h1234, 16'h0000, 1'b1);
        send_sample(16'h1234, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'h5555, 16'haaaa, 1'b0);
        send_sample(16'haaaa, 16'h5555, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0001, 16'hffff, 1'b0);
        send_sample(16'h7fff, 16'h0000, 1'b0);
        drain();

        set_lengths(4, 2);
        hold_go <= 1'b1;
        send_random(100);
        drain();

        set_lengths(16, 4);
        noidle <= 1'b1;
        send_random(80);
        drain();
        noidle <= 1'b0;

        // a write to an unused index, then out of range lengths
        write_reg(CFG_CP_LEN + 2'd2, CFG_DATA_W'($urandom));
        set_lengths(0, 0);
        send_random(30);
        drain();

        // cyclic prefix length saturates, window fills without restarts
        set_lengths(8, 1023);
        send_random(530, 0);
        drain();

        set_lengths(2, 3);
        send_random(40);
        drain();

        if (fail_cnt == 0 && pending == 0) begin
            $display("cp_correlation_timing_metric_tb passed");
        end else begin
            $display("cp_correlation_timing_metric_tb failed");
        end
        $finish;
    end

endmodule

### cp_correlation_timing_metric.f
src/cpctm_pkg.sv
src/cpctm_ifs.sv
src/cpctm_front.sv
src/cpctm_queue.sv
src/cpctm_back.sv
src/cp_correlation_timing_metric.sv
src/cpctm_checker.sv
dv/cpctm_checker.sv
dv/cp_correlation_timing_metric_tb.sv
